// ===== hdl/wspc_pkg.sv =====
// Shared types and constants for the wheel speed PI controller.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package wspc_pkg;

  // Field and register widths
  localparam int KP_W       = 24;
  localparam int NUM_W      = 20;
  localparam int SPD_W      = 16;
  localparam int PER_W      = 6;
  localparam int CAP_W      = 12;
  localparam int DRIVE_W    = 7;
  localparam int ERR_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Divider iterations: one quotient bit per cycle
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 7'd99;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KPKIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TMAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TMIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_PER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 3'd6;

  // Register reset values
  localparam logic [KP_W-1:0]  KP_RST       = 24'd671;
  localparam logic [KP_W-1:0]  KPKIT_RST    = 24'd40265;
  localparam logic [NUM_W-1:0] NUM_RST      = 20'd184200;
  localparam logic [SPD_W-1:0] TMAX_RST     = 16'd1428;
  localparam logic [SPD_W-1:0] TMIN_RST     = 16'd150;
  localparam logic [PER_W-1:0] CTRL_PER_RST = 6'd55;
  localparam logic [CAP_W-1:0] CAP_RST      = 12'd3000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MUL0,
    ST_MUL1,
    ST_ADD,
    ST_SAT,
    ST_DONE
  } wspc_state_e;

endpackage : wspc_pkg

`default_nettype wire

// ===== hdl/wspc_in_if.sv =====
// Input channel: one timer tick per transaction (encoder level, target speed).
// Depends on wspc_pkg for field widths.
`default_nettype none

interface wspc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          encoder_level;
  logic [wspc_pkg::SPD_W-1:0]    target_speed;

  modport source (output valid, output encoder_level, output target_speed, input ready);
  modport sink   (input valid, input encoder_level, input target_speed, output ready);
endinterface : wspc_in_if

`default_nettype wire

// ===== hdl/wspc_out_if.sv =====
// Output channel: one result per tick (drive, measured speed, control flag).
// Depends on wspc_pkg for field widths.
`default_nettype none

interface wspc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wspc_pkg::DRIVE_W-1:0]  drive;
  logic [wspc_pkg::SPD_W-1:0]    measured_speed;
  logic                          control_ran;

  modport source (output valid, output drive, output measured_speed, output control_ran,
                  input ready);
  modport sink   (input valid, input drive, input measured_speed, input control_ran,
                  output ready);
endinterface : wspc_out_if

`default_nettype wire

// ===== hdl/wspc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wspc_pkg for operand widths and step count.
`default_nettype none

module wspc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [wspc_pkg::NUM_W-1:0]   dividend_i,
  input  wire logic [wspc_pkg::CAP_W-1:0]   divisor_i,
  output      logic                         done_o,
  output      logic [wspc_pkg::NUM_W-1:0]   quotient_o
);

  localparam int NW = wspc_pkg::NUM_W;
  localparam int DW = wspc_pkg::CAP_W;
  localparam int CW = wspc_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] dvs_q, dvs_d;

  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial     = {rem_q, quo_q[NW-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(wspc_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef NO_ASSERTIONS
  // A zero divisor would give garbage; the period count is at least one here
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("divider started with zero divisor");

  // Completion only after the iteration has stopped
  a_div_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("divider remainder out of range");
`endif

endmodule : wspc_div

`default_nettype wire

// ===== hdl/wheel_speed_pi_control_unit.sv =====
// Wheel speed measurement and incremental PI speed control, top level.
// Depends on wspc_pkg, wspc_in_if, wspc_out_if and wspc_div.
// Usage:
//  - in_i carries one timer tick per transaction: encoder level and target
//    speed. out_o returns one result per tick: applied drive (0..99), latest
//    measured speed and a flag set when a PI step ran on that tick.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write the seven gain and limit registers
//    (kp, kpkit, speed numerator, target max, target min, control period,
//    period cap); write only while the block is idle.
//  - From input to result transaction: a plain tick goes to DONE and the
//    output register, a PI step first passes ERR, MUL0, MUL1, ADD and SAT,
//    and an encoder edge first runs the speed update in DIV. The divider
//    sets the worst case; the PI step uses one 25x18 multiplier twice.
//  - One tick at a time; in_i.ready is high only while the sequencer is idle.
//    The result sits in an output register, so the next tick is accepted
//    while the previous result waits. If the receiver stalls with a result
//    still pending, the next tick is processed and then held until the
//    output register frees up.
//  - Reset (rst_ni low, asynchronous) restores all register defaults and
//    clears the counters, speed, PI accumulator and drive.
`default_nettype none

module wheel_speed_pi_control_unit #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  wspc_in_if.sink                                in_i,
  wspc_out_if.source                             out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [wspc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [wspc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int KW     = wspc_pkg::KP_W;
  localparam int NW     = wspc_pkg::NUM_W;
  localparam int SW     = wspc_pkg::SPD_W;
  localparam int PW     = wspc_pkg::PER_W;
  localparam int CPW    = wspc_pkg::CAP_W;
  localparam int DRW    = wspc_pkg::DRIVE_W;
  localparam int EW     = wspc_pkg::ERR_W;
  localparam int ACC_W  = DRW + GAIN_FRAC_BITS;
  localparam int PROD_W = KW + 1 + EW;
  localparam int SUM_W  = ((ACC_W + 1 > PROD_W) ? ACC_W + 1 : PROD_W) + 2;

  localparam logic [ACC_W-1:0]        AccMax = {wspc_pkg::DRIVE_MAX, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] SumMax = SUM_W'(AccMax);

  // Configuration registers
  logic [KW-1:0]  kp_q, kpkit_q;
  logic [NW-1:0]  num_q;
  logic [SW-1:0]  tmax_q, tmin_q;
  logic [PW-1:0]  ctrl_per_q;
  logic [CPW-1:0] cap_q;

  // Controller state
  wspc_pkg::wspc_state_e state_q, state_d;
  logic [PW-1:0]    tick_q;
  logic [CPW-1:0]   period_q;
  logic             armed_q;
  logic [SW-1:0]    speed_q;
  logic [ACC_W-1:0] acc_q;
  logic signed [EW-1:0] last_err_q;
  logic [DRW-1:0]   drive_q;

  // Per-tick working registers
  logic             run_q;
  logic [SW-1:0]    target_q;
  logic signed [EW-1:0]     err_q, diff_q;
  logic                     ref_zero_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;

  // Output register
  logic           out_valid_q;
  logic [DRW-1:0] out_drive_q;
  logic [SW-1:0]  out_speed_q;
  logic           out_ran_q;

  logic           accept;
  logic           out_load;
  logic [PW-1:0]  tick_nxt;
  logic [CPW-1:0] cap_eff, period_inc;
  logic           edge_hit;
  logic           run_nxt;
  logic           div_done;
  logic [NW-1:0]  div_quo;
  logic [SW-1:0]  ref_speed;
  logic signed [EW-1:0]     err_nxt;
  logic signed [KW:0]       mul_a;
  logic signed [EW-1:0]     mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]         acc_sat;

  // Configuration writes; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= wspc_pkg::KP_RST;
      kpkit_q    <= wspc_pkg::KPKIT_RST;
      num_q      <= wspc_pkg::NUM_RST;
      tmax_q     <= wspc_pkg::TMAX_RST;
      tmin_q     <= wspc_pkg::TMIN_RST;
      ctrl_per_q <= wspc_pkg::CTRL_PER_RST;
      cap_q      <= wspc_pkg::CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wspc_pkg::REG_KP:       kp_q       <= cfg_data_i[KW-1:0];
        wspc_pkg::REG_KPKIT:    kpkit_q    <= cfg_data_i[KW-1:0];
        wspc_pkg::REG_NUM:      num_q      <= cfg_data_i[NW-1:0];
        wspc_pkg::REG_TMAX:     tmax_q     <= cfg_data_i[SW-1:0];
        wspc_pkg::REG_TMIN:     tmin_q     <= cfg_data_i[SW-1:0];
        wspc_pkg::REG_CTRL_PER: ctrl_per_q <= cfg_data_i[PW-1:0];
        wspc_pkg::REG_CAP:      cap_q      <= cfg_data_i[CPW-1:0];
        default: ;
      endcase
    end
  end

  // Tick bookkeeping at accept time
  assign accept     = in_i.valid && in_i.ready;
  assign tick_nxt   = tick_q + 1'b1;
  assign cap_eff    = (cap_q == '0) ? CPW'(1) : cap_q;
  assign period_inc = (period_q < cap_eff) ? period_q + 1'b1 : cap_eff;
  assign edge_hit   = armed_q && !in_i.encoder_level;
  assign run_nxt    = tick_nxt >= ctrl_per_q;

  // Speed = numerator / period count, one bit per cycle
  wspc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && edge_hit),
    .dividend_i (num_q),
    .divisor_i  (period_inc),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Target clamp: above max, then zero, then below min
  always_comb begin
    if (target_q > tmax_q) begin
      ref_speed = tmax_q;
    end else if (target_q == '0) begin
      ref_speed = '0;
    end else if (target_q < tmin_q) begin
      ref_speed = tmin_q;
    end else begin
      ref_speed = target_q;
    end
  end

  assign err_nxt = $signed({2'b00, ref_speed}) - $signed({2'b00, speed_q});

  // Shared multiplier: kp * error difference, then kpkit * error
  assign mul_a = (state_q == wspc_pkg::ST_MUL1) ? $signed({1'b0, kpkit_q})
                                                : $signed({1'b0, kp_q});
  assign mul_b = (state_q == wspc_pkg::ST_MUL1) ? err_q : diff_q;
  assign mul_p = mul_a * mul_b;

  // Hold u within 0..99 in gain fixed point
  always_comb begin
    if (sum_q > SumMax) begin
      acc_sat = AccMax;
    end else if (sum_q < 0) begin
      acc_sat = '0;
    end else begin
      acc_sat = sum_q[ACC_W-1:0];
    end
  end

  assign out_load = (state_q == wspc_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wspc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    case (state_q)
      wspc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (edge_hit) begin
            state_d = wspc_pkg::ST_DIV;
          end else if (run_nxt) begin
            state_d = wspc_pkg::ST_ERR;
          end else begin
            state_d = wspc_pkg::ST_DONE;
          end
        end
      end
      wspc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = run_q ? wspc_pkg::ST_ERR : wspc_pkg::ST_DONE;
        end
      end
      wspc_pkg::ST_ERR:  state_d = wspc_pkg::ST_MUL0;
      wspc_pkg::ST_MUL0: state_d = wspc_pkg::ST_MUL1;
      wspc_pkg::ST_MUL1: state_d = wspc_pkg::ST_ADD;
      wspc_pkg::ST_ADD:  state_d = wspc_pkg::ST_SAT;
      wspc_pkg::ST_SAT:  state_d = wspc_pkg::ST_DONE;
      wspc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = wspc_pkg::ST_IDLE;
        end
      end
      default: state_d = wspc_pkg::ST_IDLE;
    endcase
  end

  // Controller state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      period_q   <= '0;
      armed_q    <= 1'b0;
      speed_q    <= '0;
      acc_q      <= '0;
      last_err_q <= '0;
      drive_q    <= '0;
    end else begin
      if (accept) begin
        tick_q <= run_nxt ? '0 : tick_nxt;
        if (edge_hit) begin
          period_q <= '0;
          armed_q  <= 1'b0;
        end else begin
          period_q <= period_inc;
          if (in_i.encoder_level) begin
            armed_q <= 1'b1;
          end
        end
      end
      if (state_q == wspc_pkg::ST_DIV && div_done) begin
        speed_q <= (|div_quo[NW-1:SW]) ? {SW{1'b1}} : div_quo[SW-1:0];
      end
      if (state_q == wspc_pkg::ST_SAT) begin
        acc_q      <= acc_sat;
        last_err_q <= err_q;
        drive_q    <= ref_zero_q ? '0 : acc_sat[ACC_W-1:GAIN_FRAC_BITS];
      end
    end
  end

  // PI working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_q    <= run_nxt;
      target_q <= in_i.target_speed;
    end
    case (state_q)
      wspc_pkg::ST_ERR: begin
        err_q      <= err_nxt;
        diff_q     <= err_nxt - last_err_q;
        ref_zero_q <= (ref_speed == '0);
      end
      wspc_pkg::ST_MUL0: prod_q <= mul_p;
      wspc_pkg::ST_MUL1: begin
        sum_q  <= $signed(SUM_W'({1'b0, acc_q})) - SUM_W'(prod_q);
        prod_q <= mul_p;
      end
      wspc_pkg::ST_ADD:  sum_q <= sum_q + SUM_W'(prod_q);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_drive_q <= drive_q;
      out_speed_q <= speed_q;
      out_ran_q   <= run_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.drive          = out_drive_q;
  assign out_o.measured_speed = out_speed_q;
  assign out_o.control_ran    = out_ran_q;

`ifndef NO_ASSERTIONS
  // Held PI output never leaves 0..99 in fixed point
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= AccMax)
    else $error("PI accumulator out of range");

  // Applied drive stays a valid duty percent
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q <= wspc_pkg::DRIVE_MAX)
    else $error("drive above maximum duty");

  // A falling edge after a high level restarts the period count
  a_edge_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && edge_hit) |=> (period_q == '0 && !armed_q))
    else $error("period count not restarted on edge");
`endif

endmodule : wheel_speed_pi_control_unit

`default_nettype wire
